// ===== rtl/v3a_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_pkg
// Shared constants for the three-component fixed-point vector ALU: default
// word and fraction widths and the opcode values.
// ============================================================================
package v3a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int OP_W          = 4;

    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_SCALE = 4'd2;
    localparam logic [OP_W-1:0] OP_DOT   = 4'd3;
    localparam logic [OP_W-1:0] OP_CROSS = 4'd4;
    localparam logic [OP_W-1:0] OP_LEN   = 4'd5;
    localparam logic [OP_W-1:0] OP_LENSQ = 4'd6;
    localparam logic [OP_W-1:0] OP_NORM  = 4'd7;
    localparam logic [OP_W-1:0] OP_CLAMP = 4'd8;

endpackage

// ===== rtl/v3a_req_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_req_if
// Request channel: opcode, two vectors and a scale factor, valid/ready.
// ============================================================================
interface v3a_req_if #(
    parameter int W = v3a_pkg::WORD_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic [v3a_pkg::OP_W-1:0]   op;
    logic signed [W-1:0]        a_x;
    logic signed [W-1:0]        a_y;
    logic signed [W-1:0]        a_z;
    logic signed [W-1:0]        b_x;
    logic signed [W-1:0]        b_y;
    logic signed [W-1:0]        b_z;
    logic signed [W-1:0]        scale_factor;

    modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                    input ready);
    modport sink   (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                    output ready);
endinterface

// ===== rtl/v3a_res_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_res_if
// Result channel: vector, scalar and two flags, valid/ready.
// ============================================================================
interface v3a_res_if #(
    parameter int W = v3a_pkg::WORD_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_x;
    logic signed [W-1:0] res_y;
    logic signed [W-1:0] res_z;
    logic signed [W-1:0] res_scalar;
    logic                saturated;
    logic                zero_length;

    modport source (output valid, res_x, res_y, res_z, res_scalar, saturated, zero_length,
                    input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_scalar, saturated, zero_length,
                    output ready);
endinterface

// ===== rtl/vec3_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vec3_fixed_point_alu_unit
// Three-component vector ALU in signed fixed point: add, sub, scale, dot,
// cross, length, squared length, normalize and clamp to [0,1].
// ============================================================================
// Takes one request per cycle unless the result side stalls, and returns one
// result per request, in order. Every request walks the same pipeline of
// WORD_BITS + FRAC_BITS + 5 stages (Q16.16 by default): three stages of
// operand select, multiply and combine, WORD_BITS square-root stages of one
// root bit each, FRAC_BITS + 1 divider stages of one quotient bit each for
// the normalize lanes, and the output register. When the result side stalls
// the whole pipeline holds and ready drops; nothing is lost or repeated.
module vec3_fixed_point_alu_unit #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    v3a_req_if.sink     i_req,
    v3a_res_if.source   o_res
);
    import v3a_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SW  = 7 * W + 8;
    localparam int QW  = F + W + 2;
    localparam logic [QW-1:0] MAXQ = QW'({(W-1){1'b1}});
    localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};

    logic en;
    assign en = !o_res.valid || o_res.ready;
    assign i_req.ready = en;

    logic            f_vld;
    logic [SW-1:0]   f_side;
    logic [2*W-1:0]  f_rad;

    v3a_front #(.W(W), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_req.valid),
        .i_op    (i_req.op),
        .i_a     ({i_req.a_z, i_req.a_y, i_req.a_x}),
        .i_b     ({i_req.b_z, i_req.b_y, i_req.b_x}),
        .i_s     (i_req.scale_factor),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    logic            q_vld;
    logic [W-1:0]    q_root;
    logic [SW-1:0]   q_side;

    v3a_sqrt #(.W(W), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_vld   (q_vld),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    logic              d_vld;
    logic [W-1:0]      d_len;
    logic [2:0][F:0]   d_quo;
    logic [SW-1:0]     d_side;

    v3a_div #(.W(W), .F(F), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (q_vld),
        .i_den   (q_root),
        .i_mag   (q_side[4*W +: 3*W]),
        .i_side  (q_side),
        .o_vld   (d_vld),
        .o_den   (d_len),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // side word: {op, flag, signs, magnitudes, scalar, vector}
    logic [OP_W-1:0]    d_op;
    logic               d_flag;
    logic [2:0]         d_sgn;
    logic [2:0][W-1:0]  d_vec;
    logic [W-1:0]       d_scal;

    assign d_op   = d_side[SW-1 -: OP_W];
    assign d_flag = d_side[7*W+3];
    assign d_sgn  = d_side[7*W +: 3];
    assign d_scal = d_side[3*W +: W];
    assign d_vec  = d_side[0 +: 3*W];

    logic [2:0][W-1:0]  n_vec;
    logic [W-1:0]       n_scal;
    logic               n_flag, n_zlen;
    logic [QW-1:0]      qx;

    always_comb begin
        n_vec  = d_vec;
        n_scal = d_scal;
        n_flag = d_flag;
        n_zlen = 1'b0;
        qx     = '0;
        case (d_op)
            OP_LEN: begin
                if (d_len[W-1]) begin
                    n_scal = MAXW;
                    n_flag = 1'b1;
                end else begin
                    n_scal = d_len;
                end
            end
            OP_NORM: begin
                if (d_len == '0) begin
                    n_zlen = 1'b1;
                    n_vec  = '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        qx = QW'(d_quo[i]);
                        if (!d_sgn[i]) begin
                            if (qx > MAXQ) begin
                                n_vec[i] = MAXW;
                                n_flag   = 1'b1;
                            end else begin
                                n_vec[i] = qx[W-1:0];
                            end
                        end else begin
                            if (qx > MAXQ + QW'(1)) begin
                                n_vec[i] = ~MAXW;
                                n_flag   = 1'b1;
                            end else begin
                                n_vec[i] = W'(QW'(0) - qx);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    logic               r_vld;
    logic [2:0][W-1:0]  r_vec;
    logic [W-1:0]       r_scal;
    logic               r_flag, r_zlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (en) r_vld <= d_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec  <= n_vec;
            r_scal <= n_scal;
            r_flag <= n_flag;
            r_zlen <= n_zlen;
        end
    end

    assign o_res.valid       = r_vld;
    assign o_res.res_x       = r_vec[0];
    assign o_res.res_y       = r_vec[1];
    assign o_res.res_z       = r_vec[2];
    assign o_res.res_scalar  = r_scal;
    assign o_res.saturated   = r_flag;
    assign o_res.zero_length = r_zlen;

`ifndef SYNTHESIS
    a_zero_len_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.zero_length |->
            o_res.res_x == '0 && o_res.res_y == '0 && o_res.res_z == '0 &&
            o_res.res_scalar == '0)
        else $error("zero_length result with nonzero value");

    a_zero_len_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.zero_length |-> !o_res.saturated)
        else $error("zero_length and saturated both set");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_res.valid || o_res.ready))
        else $error("request ready not tied to result stall");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.res_scalar))
        else $error("result changed while stalled");
`endif

endmodule

// ===== rtl/v3a_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_front
// Three stages: operand select, six shared multipliers, then combine with
// shift and saturation. Also forms the sum of squares for the root stages.
// ============================================================================
module v3a_front #(
    parameter int W = v3a_pkg::WORD_BITS_DEF,
    parameter int F = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [v3a_pkg::OP_W-1:0]   i_op,
    input  logic [2:0][W-1:0]          i_a,
    input  logic [2:0][W-1:0]          i_b,
    input  logic [W-1:0]               i_s,
    output logic                       o_vld,
    output logic [7*W+7:0]             o_side,
    output logic [2*W-1:0]             o_rad
);
    import v3a_pkg::*;

    localparam int XW = 2 * W + 3;
    localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] MINV = ~MAXV;
    localparam logic                 ONE_SAT = (F >= W - 1);
    localparam logic signed [XW-1:0] ONE_X = ONE_SAT ? MAXV : (XW'(1) << F);

    function automatic logic [W:0] sat_w(input logic signed [XW-1:0] v);
        logic [W:0] r;
        if (v > MAXV)      r = {1'b1, MAXV[W-1:0]};
        else if (v < MINV) r = {1'b1, MINV[W-1:0]};
        else               r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // stage 1: operand select
    logic [5:0][W-1:0]  n_mx, n_my;
    logic               r1_vld;
    logic [OP_W-1:0]    r1_op;
    logic [2:0][W-1:0]  r1_a, r1_b;
    logic [5:0][W-1:0]  r1_mx, r1_my;

    always_comb begin
        n_mx = '0;
        n_my = '0;
        for (int i = 0; i < 3; i++) begin
            n_mx[i] = i_a[i];
            n_my[i] = i_b[i];
        end
        case (i_op) inside
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) n_my[i] = i_s;
            end
            OP_CROSS: begin
                n_mx[0] = i_a[1]; n_my[0] = i_b[2];
                n_mx[1] = i_a[2]; n_my[1] = i_b[0];
                n_mx[2] = i_a[0]; n_my[2] = i_b[1];
                n_mx[3] = i_a[2]; n_my[3] = i_b[1];
                n_mx[4] = i_a[0]; n_my[4] = i_b[2];
                n_mx[5] = i_a[1]; n_my[5] = i_b[0];
            end
            OP_LEN, OP_LENSQ, OP_NORM: begin
                for (int i = 0; i < 3; i++) n_my[i] = i_a[i];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (i_en) r1_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op <= i_op;
            r1_a  <= i_a;
            r1_b  <= i_b;
            r1_mx <= n_mx;
            r1_my <= n_my;
        end
    end

    // stage 2: products
    logic               r2_vld;
    logic [OP_W-1:0]    r2_op;
    logic [2:0][W-1:0]  r2_a, r2_b;
    logic [5:0][2*W-1:0] r2_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (i_en) r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op <= r1_op;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            for (int i = 0; i < 6; i++) r2_p[i] <= $signed(r1_mx[i]) * $signed(r1_my[i]);
        end
    end

    // stage 3: combine, shift, saturate
    logic signed [XW-1:0] ea [3];
    logic signed [XW-1:0] eb [3];
    logic signed [XW-1:0] ep [6];
    logic signed [XW-1:0] sum3;
    logic [2:0][W-1:0]    n_vec, n_mag;
    logic [W-1:0]         n_scal;
    logic [2:0]           n_sgn;
    logic                 n_flag;
    logic [W:0]           t;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ea[i] = XW'($signed(r2_a[i]));
            eb[i] = XW'($signed(r2_b[i]));
        end
        for (int i = 0; i < 6; i++) ep[i] = XW'($signed(r2_p[i]));
        sum3   = ep[0] + ep[1] + ep[2];
        n_vec  = '0;
        n_scal = '0;
        n_flag = 1'b0;
        t      = '0;
        for (int i = 0; i < 3; i++) begin
            n_sgn[i] = r2_a[i][W-1];
            n_mag[i] = r2_a[i][W-1] ? (~r2_a[i] + W'(1)) : r2_a[i];
        end
        case (r2_op) inside
            OP_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    t = sat_w(ea[i] + eb[i]);
                    n_vec[i] = t[W-1:0];
                    n_flag |= t[W];
                end
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    t = sat_w(ea[i] - eb[i]);
                    n_vec[i] = t[W-1:0];
                    n_flag |= t[W];
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    t = sat_w(ep[i] >>> F);
                    n_vec[i] = t[W-1:0];
                    n_flag |= t[W];
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    t = sat_w((ep[i] - ep[i+3]) >>> F);
                    n_vec[i] = t[W-1:0];
                    n_flag |= t[W];
                end
            end
            OP_DOT, OP_LENSQ: begin
                t = sat_w(sum3 >>> F);
                n_scal = t[W-1:0];
                n_flag = t[W];
            end
            OP_CLAMP: begin
                n_flag = ONE_SAT;
                for (int i = 0; i < 3; i++) begin
                    if (ea[i] < 0)          n_vec[i] = '0;
                    else if (ea[i] > ONE_X) n_vec[i] = ONE_X[W-1:0];
                    else                    n_vec[i] = r2_a[i];
                end
            end
            default: ;
        endcase
    end

    logic               r3_vld;
    logic [OP_W-1:0]    r3_op;
    logic               r3_flag;
    logic [2:0]         r3_sgn;
    logic [2:0][W-1:0]  r3_mag, r3_vec;
    logic [W-1:0]       r3_scal;
    logic [2*W-1:0]     r3_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (i_en) r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_op   <= r2_op;
            r3_flag <= n_flag;
            r3_sgn  <= n_sgn;
            r3_mag  <= n_mag;
            r3_vec  <= n_vec;
            r3_scal <= n_scal;
            // squares are non-negative and their sum stays below 2^(2W)
            r3_rad  <= sum3[2*W-1:0];
        end
    end

    assign o_vld  = r3_vld;
    assign o_side = {r3_op, r3_flag, r3_sgn, r3_mag, r3_scal, r3_vec};
    assign o_rad  = r3_rad;

endmodule

// ===== rtl/v3a_sqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_sqrt
// Pipelined integer square root, one root bit per stage, W stages.
// Keeps the remainder n - r^2 and tests the next bit against it.
// ============================================================================
module v3a_sqrt #(
    parameter int W  = v3a_pkg::WORD_BITS_DEF,
    parameter int SW = 7 * v3a_pkg::WORD_BITS_DEF + 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2*W-1:0]  i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [W-1:0]    o_root,
    output logic [SW-1:0]   o_side
);
    wire            s_vld  [W+1];
    wire [2*W-1:0]  s_rem  [W+1];
    wire [W-1:0]    s_root [W+1];
    wire [SW-1:0]   s_side [W+1];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = i_rad;
    assign s_root[0] = '0;
    assign s_side[0] = i_side;

    for (genvar g = 0; g < W; g++) begin : g_stage
        localparam int K = W - 1 - g;
        logic [2*W-1:0] trial, n_rem;
        logic [W-1:0]   n_root;
        logic           r_vld;
        logic [2*W-1:0] r_rem;
        logic [W-1:0]   r_root;
        logic [SW-1:0]  r_side;

        // (r + 2^K)^2 - r^2 = (2r + 2^K) * 2^K
        always_comb begin
            trial = ({{W{1'b0}}, s_root[g]} << (K + 1)) | ((2*W)'(1) << (2 * K));
            if (s_rem[g] >= trial) begin
                n_rem  = s_rem[g] - trial;
                n_root = s_root[g] | (W'(1) << K);
            end else begin
                n_rem  = s_rem[g];
                n_root = s_root[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld <= 1'b0;
            else if (i_en) r_vld <= s_vld[g];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= s_side[g];
            end
        end

        assign s_vld[g+1]  = r_vld;
        assign s_rem[g+1]  = r_rem;
        assign s_root[g+1] = r_root;
        assign s_side[g+1] = r_side;
    end

    assign o_vld  = s_vld[W];
    assign o_root = s_root[W];
    assign o_side = s_side[W];

endmodule

// ===== rtl/v3a_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_div
// Three-lane pipelined restoring divider, F+1 stages: |a_i| * 2^F / L.
// Since |a_i| <= L, the quotient fits in F+1 bits.
// ============================================================================
module v3a_div #(
    parameter int W  = v3a_pkg::WORD_BITS_DEF,
    parameter int F  = v3a_pkg::FRAC_BITS_DEF,
    parameter int SW = 7 * v3a_pkg::WORD_BITS_DEF + 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [W-1:0]      i_den,
    input  logic [2:0][W-1:0] i_mag,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [W-1:0]      o_den,
    output logic [2:0][F:0]   o_quo,
    output logic [SW-1:0]     o_side
);
    wire              s_vld  [F+2];
    wire [W-1:0]      s_den  [F+2];
    wire [2:0][W:0]   s_rem  [F+2];
    wire [2:0][F:0]   s_quo  [F+2];
    wire [SW-1:0]     s_side [F+2];

    assign s_vld[0]  = i_vld;
    assign s_den[0]  = i_den;
    assign s_rem[0]  = {{1'b0, i_mag[2]}, {1'b0, i_mag[1]}, {1'b0, i_mag[0]}};
    assign s_quo[0]  = '0;
    assign s_side[0] = i_side;

    for (genvar j = 0; j <= F; j++) begin : g_stage
        logic [2:0][W:0] shf, n_rem;
        logic [2:0][F:0] n_quo;
        logic            r_vld;
        logic [W-1:0]    r_den;
        logic [2:0][W:0] r_rem;
        logic [2:0][F:0] r_quo;
        logic [SW-1:0]   r_side;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                // first step tests the integer bit, later steps shift in a zero
                shf[k]   = (j == 0) ? s_rem[j][k] : {s_rem[j][k][W-1:0], 1'b0};
                n_quo[k] = s_quo[j][k];
                if (shf[k] >= {1'b0, s_den[j]}) begin
                    n_rem[k]       = shf[k] - {1'b0, s_den[j]};
                    n_quo[k][F-j]  = 1'b1;
                end else begin
                    n_rem[k] = shf[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld <= 1'b0;
            else if (i_en) r_vld <= s_vld[j];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den  <= s_den[j];
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_side <= s_side[j];
            end
        end

        assign s_vld[j+1]  = r_vld;
        assign s_den[j+1]  = r_den;
        assign s_rem[j+1]  = r_rem;
        assign s_quo[j+1]  = r_quo;
        assign s_side[j+1] = r_side;
    end

    assign o_vld  = s_vld[F+1];
    assign o_den  = s_den[F+1];
    assign o_quo  = s_quo[F+1];
    assign o_side = s_side[F+1];

endmodule

// ===== sim/v3a_alu_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_alu_checker
// Passive scoreboard for the vector ALU: predicts each accepted request in
// wide exact arithmetic and compares every accepted result in order.
// ============================================================================
module v3a_alu_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    v3a_req_if    i_req,
    v3a_res_if    i_res,
    output int    o_fail_cnt,
    output int    o_pending,
    output int    o_checked
);
    import v3a_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] scalar;
        logic        sat;
        logic        zlen;
    } alu_result_t;

    alu_result_t expected_q[$];
    int fail_cnt = 0;
    int checked  = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = expected_q.size();
    assign o_checked  = checked;

    function automatic logic [31:0] clip(input wide_t v, inout logic flag);
        if (v > wide_t'(32'sh7FFF_FFFF)) begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -wide_t'(33'sh8000_0000)) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic wide_t sx(input logic [31:0] v);
        return wide_t'($signed(v));
    endfunction

    function automatic logic [127:0] floor_root(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int bitpos = 32; bitpos >= 0; bitpos--) begin
            c = r | (128'd1 << bitpos);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic alu_result_t alu_predict(input logic [OP_W-1:0] op,
                                                input logic [31:0] ax, ay, az,
                                                input logic [31:0] bx, by, bz,
                                                input logic [31:0] sf);
        alu_result_t  r;
        wide_t        a[3];
        wide_t        b[3];
        wide_t        s;
        wide_t        sq;
        wide_t        q;
        logic [127:0] len;
        logic         flag;
        logic [31:0]  v[3];
        a[0] = sx(ax); a[1] = sx(ay); a[2] = sx(az);
        b[0] = sx(bx); b[1] = sx(by); b[2] = sx(bz);
        s = sx(sf);
        flag = 1'b0;
        v[0] = '0; v[1] = '0; v[2] = '0;
        r = '0;
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        case (op)
            OP_ADD:   for (int i = 0; i < 3; i++) v[i] = clip(a[i] + b[i], flag);
            OP_SUB:   for (int i = 0; i < 3; i++) v[i] = clip(a[i] - b[i], flag);
            OP_SCALE: for (int i = 0; i < 3; i++) v[i] = clip((a[i] * s) >>> 16, flag);
            OP_DOT: begin
                r.scalar = clip((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16, flag);
            end
            OP_CROSS: begin
                v[0] = clip((a[1] * b[2] - a[2] * b[1]) >>> 16, flag);
                v[1] = clip((a[2] * b[0] - a[0] * b[2]) >>> 16, flag);
                v[2] = clip((a[0] * b[1] - a[1] * b[0]) >>> 16, flag);
            end
            OP_LEN:   r.scalar = clip(wide_t'(floor_root(sq)), flag);
            OP_LENSQ: r.scalar = clip(sq >>> 16, flag);
            OP_NORM: begin
                len = floor_root(sq);
                if (len == 0) begin
                    r.zlen = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q = wide_t'(((a[i] < 0 ? -a[i] : a[i]) << 16) / len);
                        v[i] = clip(a[i] < 0 ? -q : q, flag);
                    end
                end
            end
            OP_CLAMP: begin
                for (int i = 0; i < 3; i++) begin
                    if (a[i] < 0) v[i] = '0;
                    else if (a[i] > 65536) v[i] = 32'd65536;
                    else v[i] = a[i][31:0];
                end
            end
            default: ;
        endcase
        r.x = v[0]; r.y = v[1]; r.z = v[2];
        r.sat = flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        alu_result_t e;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                expected_q.push_back(alu_predict(i_req.op, i_req.a_x, i_req.a_y, i_req.a_z,
                                                 i_req.b_x, i_req.b_y, i_req.b_z,
                                                 i_req.scale_factor));
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    checked++;
                    if (i_res.res_x !== e.x) begin
                        $error("res_x exp %h got %h", e.x, i_res.res_x); fail_cnt++;
                    end
                    if (i_res.res_y !== e.y) begin
                        $error("res_y exp %h got %h", e.y, i_res.res_y); fail_cnt++;
                    end
                    if (i_res.res_z !== e.z) begin
                        $error("res_z exp %h got %h", e.z, i_res.res_z); fail_cnt++;
                    end
                    if (i_res.res_scalar !== e.scalar) begin
                        $error("res_scalar exp %h got %h", e.scalar, i_res.res_scalar);
                        fail_cnt++;
                    end
                    if (i_res.saturated !== e.sat) begin
                        $error("saturated exp %b got %b", e.sat, i_res.saturated);
                        fail_cnt++;
                    end
                    if (i_res.zero_length !== e.zlen) begin
                        $error("zero_length exp %b got %b", e.zlen, i_res.zero_length);
                        fail_cnt++;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_vec3_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_vec3_fixed_point_alu_unit
// Drives directed corner requests and then random bursts into the vector ALU
// with a stalling result side; the checker predicts and compares each result.
// ============================================================================
module tb_vec3_fixed_point_alu_unit;
    import v3a_pkg::*;

    localparam int N_RANDOM  = 700;
    localparam int LATENCY   = 53;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_cnt, pending, checked;
    int   cycle = 0;
    int   sent = 0;
    int   odd_ops = 0;

    v3a_req_if u_req_if ();
    v3a_res_if u_res_if ();

    vec3_fixed_point_alu_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req_if),
        .o_res   (u_res_if)
    );

    v3a_alu_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (u_req_if),
        .i_res      (u_res_if),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: alternating stretches of free flow, random stalls, long stalls
    always @(posedge i_clk) begin
        case ((cycle / 300) % 4)
            0:       u_res_if.ready <= 1'b1;
            1:       u_res_if.ready <= ($urandom_range(0, 3) != 0);
            2:       u_res_if.ready <= ($urandom_range(0, 1) != 0);
            default: u_res_if.ready <= ((cycle % 23) > 15);
        endcase
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'($signed($urandom_range(0, 2)) - 1);
            5:       return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op,
                            input logic [31:0] ax, ay, az, bx, by, bz, sf);
        u_req_if.valid        <= 1'b1;
        u_req_if.op           <= op;
        u_req_if.a_x          <= ax;
        u_req_if.a_y          <= ay;
        u_req_if.a_z          <= az;
        u_req_if.b_x          <= bx;
        u_req_if.b_y          <= by;
        u_req_if.b_z          <= bz;
        u_req_if.scale_factor <= sf;
        do @(posedge i_clk); while (!u_req_if.ready);
        sent++;
        if (op > OP_CLAMP) odd_ops++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            u_req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        idle_gap(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] mx, mn, one;
        logic [OP_W-1:0] op;
        int burst;
        bit mid_drained;
        mx  = 32'h7FFF_FFFF;
        mn  = 32'h8000_0000;
        one = 32'h0001_0000;
        mid_drained = 1'b0;
        i_rst_n <= 1'b0;
        u_req_if.valid <= 1'b0;
        u_req_if.op <= OP_ADD;
        u_req_if.a_x <= '0; u_req_if.a_y <= '0; u_req_if.a_z <= '0;
        u_req_if.b_x <= '0; u_req_if.b_y <= '0; u_req_if.b_z <= '0;
        u_req_if.scale_factor <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_req(OP_ADD,   mx, mn, one, mx, mn, 32'hFFFF_0000, '0);
        send_req(OP_SUB,   mn, mx, '0, 32'd1, mn, mx, '0);
        send_req(OP_SCALE, mx, mn, one, '0, '0, '0, mx);
        send_req(OP_SCALE, mn, mn, 32'hFFFF_FFFF, '0, '0, '0, mn);
        send_req(OP_SCALE, 32'd3, 32'hFFFF_FFFD, one, '0, '0, '0, 32'h0000_8000);
        send_req(OP_DOT,   mx, mx, mx, mx, mx, mx, '0);
        send_req(OP_DOT,   mn, mn, mn, mx, mx, mx, '0);
        send_req(OP_CROSS, one, '0, '0, '0, one, '0, '0);
        send_req(OP_CROSS, '0, '0, one, one, '0, '0, '0);
        send_req(OP_CROSS, mx, mn, mx, mn, mx, mn, '0);
        send_req(OP_LEN,   mn, mn, mn, '0, '0, '0, '0);
        send_req(OP_LEN,   32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
        send_req(OP_LENSQ, mx, mx, mx, '0, '0, '0, '0);
        send_req(OP_LENSQ, 32'hFFFF_FFFF, 32'd1, '0, '0, '0, '0, '0);
        send_req(OP_NORM,  '0, '0, '0, '0, '0, '0, '0);
        send_req(OP_NORM,  32'd1, '0, '0, '0, '0, '0, '0);
        send_req(OP_NORM,  mn, mx, 32'hFFFF_0000, '0, '0, '0, '0);
        send_req(OP_NORM,  32'hFFFF_FFFF, 32'd1, 32'd1, '0, '0, '0, '0);
        send_req(OP_CLAMP, mn, mx, one, '0, '0, '0, '0);
        send_req(OP_CLAMP, 32'hFFFF_FFFF, 32'h0001_0001, 32'h0000_8000, '0, '0, '0, '0);
        for (int k = 1; k <= 7; k++)
            send_req(OP_CLAMP + OP_W'(k), mx, mn, one, mx, mn, one, mx);

        // random bursts
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(9, 15))
                                                  : OP_W'($urandom_range(0, 8));
                send_req(op, pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(), pick_word(), pick_word());
            end
            if (!mid_drained && n >= N_RANDOM / 2) begin
                mid_drained = 1'b1;
                wait_drained();
            end else begin
                idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d requests (all nine operations plus %0d unused codes), %0d checked.",
                 sent, odd_ops, checked);
        if (fail_cnt == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== vec3_fixed_point_alu_unit.f =====
rtl/v3a_pkg.sv
rtl/v3a_req_if.sv
rtl/v3a_res_if.sv
rtl/v3a_front.sv
rtl/v3a_sqrt.sv
rtl/v3a_div.sv
rtl/vec3_fixed_point_alu_unit.sv
sim/v3a_alu_checker.sv
sim/tb_vec3_fixed_point_alu_unit.sv
